>>> rtl/ledtw_pkg.sv
// ----------------------------------------------------------------------------
// ledtw_pkg: shared types and constants of the two-wire LED display writer
// Command and status codes, frame bytes and the classified word format
// that travels from the front end through the queue to the bus sequencer.
// ----------------------------------------------------------------------------
package ledtw_pkg;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_BRIGHT  = 2'd1,
		CMD_DIGIT   = 2'd2,
		CMD_REFRESH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NACK_ADDR = 2'd1,
		ST_NACK_DATA = 2'd2,
		ST_REJECT    = 2'd3
	} status_t;

	localparam logic [7:0] BRIGHT_ADDR   = 8'h48;
	localparam logic [7:0] DIGIT_ADDR    = 8'h68;
	localparam logic [7:0] REFRESH_LEVEL = 8'h51;
	localparam logic [7:0] LEVEL_OFF     = 8'h00;
	localparam logic [7:0] LEVEL_MAX_CODE = 8'h01;
	localparam logic [3:0] MAX_LEVEL     = 4'd8;

	// classified input word
	typedef struct packed {
		logic        tick;
		logic        sda;
		cmd_t        cmd;
		logic        reject;
		logic [7:0]  addr_byte;
		logic [7:0]  data_byte;
		logic [31:0] patterns;
	} item_t;

	// queue fill status seen by the front end and the sequencer
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// brightness code: on bit in bit 0, level in bits 6..4, eight wraps to zero
	function automatic logic [7:0] level_code(input logic [3:0] lvl);
		logic [7:0] code;
		if (lvl == 4'd0) begin
			code = LEVEL_OFF;
		end else if (lvl == MAX_LEVEL) begin
			code = LEVEL_MAX_CODE;
		end else begin
			code = {1'b0, lvl[2:0], 4'h1};
		end
		return code;
	endfunction

endpackage

>>> rtl/ledtw_in_if.sv
// ----------------------------------------------------------------------------
// ledtw_in_if: input channel of the display writer
// One word per cycle of the bus while ready is high: tick, sampled data level and a command.
// ----------------------------------------------------------------------------
interface ledtw_in_if;
	logic        valid;
	logic        ready;
	logic        tick;
	logic        data_line_in;
	logic [1:0]  command;
	logic [3:0]  level;
	logic [1:0]  digit;
	logic [7:0]  segment;
	logic [31:0] four_segments;

	modport source (
		output valid, tick, data_line_in, command, level, digit, segment, four_segments,
		input  ready
	);
	modport sink (
		input  valid, tick, data_line_in, command, level, digit, segment, four_segments,
		output ready
	);
endinterface

>>> rtl/ledtw_out_if.sv
// ----------------------------------------------------------------------------
// ledtw_out_if: result channel of the display writer
// Line levels, busy flag and completion status for each input word.
// ----------------------------------------------------------------------------
interface ledtw_out_if;
	logic       valid;
	logic       ready;
	logic       clock_line;
	logic       data_release;
	logic       busy_res;
	logic       finished;
	logic [1:0] status;

	modport source (
		output valid, clock_line, data_release, busy_res, finished, status,
		input  ready
	);
	modport sink (
		input  valid, clock_line, data_release, busy_res, finished, status,
		output ready
	);
endinterface

>>> rtl/ledtw_front.sv
// ----------------------------------------------------------------------------
// ledtw_front: input stage of the display writer
// Accepts words, decodes the command into frame bytes and a reject flag,
// and pushes the classified word into the queue.
// ----------------------------------------------------------------------------
module ledtw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	ledtw_in_if.sink             item,
	input  ledtw_pkg::qstat_t    qstat,
	output logic                 push,
	output ledtw_pkg::item_t     push_data
);

	logic             valid_s1;
	ledtw_pkg::item_t item_s1;
	ledtw_pkg::item_t classed;
	logic             accept;

	// stage is free when empty or draining into the queue this cycle
	assign push      = valid_s1 && !qstat.full;
	assign item.ready = !valid_s1 || !qstat.full;
	assign accept    = item.valid && item.ready;
	assign push_data = item_s1;

	// decode the command into frame bytes
	always_comb begin
		classed.tick      = item.tick;
		classed.sda       = item.data_line_in;
		classed.cmd       = ledtw_pkg::cmd_t'(item.command);
		classed.reject    = 1'b0;
		classed.addr_byte = ledtw_pkg::BRIGHT_ADDR;
		classed.data_byte = ledtw_pkg::level_code(item.level);
		classed.patterns  = item.four_segments;
		case (classed.cmd)
			ledtw_pkg::CMD_BRIGHT: begin
				classed.reject = (item.level > ledtw_pkg::MAX_LEVEL);
			end
			ledtw_pkg::CMD_DIGIT: begin
				classed.addr_byte = ledtw_pkg::DIGIT_ADDR + {5'd0, item.digit, 1'b0};
				classed.data_byte = item.segment;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= classed;
		end
	end

endmodule

>>> rtl/ledtw_queue.sv
// ----------------------------------------------------------------------------
// ledtw_queue: two-entry queue between front end and sequencer
// Lets the front end keep accepting while the result side stalls.
// ----------------------------------------------------------------------------
module ledtw_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ledtw_pkg::item_t  push_data,
	input  logic              pop,
	output ledtw_pkg::item_t  head,
	output ledtw_pkg::qstat_t qstat
);

	ledtw_pkg::item_t entry_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);
	assign head        = entry_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

endmodule

>>> rtl/ledtw_back.sv
// ----------------------------------------------------------------------------
// ledtw_back: bus sequencer of the display writer
// Steps the start / byte / ack / stop phases once per queued word and
// holds the line levels and status in the result register.
// ----------------------------------------------------------------------------
module ledtw_back #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        short_delay_ticks,
	input  ledtw_pkg::item_t  head,
	input  ledtw_pkg::qstat_t qstat,
	output logic              pop,
	ledtw_out_if.source       result
);

	typedef enum logic [4:0] {
		P_IDLE, P_PRE, P_STA, P_STB, P_B1L, P_B1H, P_B1T, P_A1H, P_A1L, P_A1N,
		P_B2L, P_B2H, P_B2T, P_A2H, P_A2L, P_A2N, P_SPA, P_SPB,
		P_SN1A, P_SN1B, P_SN2A, P_SN2B, P_GAP
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [8:0]          delay_q, delay_d;
	logic [2:0]          bit_q, bit_d;
	logic [7:0]          shift_q, shift_d;
	logic [7:0]          second_q, second_d;
	logic [1:0]          refresh_q, refresh_d;
	logic [31:0]         saved_q, saved_d;
	ledtw_pkg::cmd_t     active_q, active_d;
	logic                fin_d;
	ledtw_pkg::status_t  st_d;
	logic                clk_d, dat_d;

	logic                out_valid_q;
	logic                clk_line_q, dat_rel_q, busy_q, fin_q;
	ledtw_pkg::status_t  st_q;

	logic                bright;
	logic [7:0]          s_ticks;
	logic [8:0]          target;
	logic                long_ph;
	logic [2:0]          shamt;

	// take a word when the result register is free or being drained
	assign pop = !qstat.empty && (!out_valid_q || result.ready);

	assign result.valid        = out_valid_q;
	assign result.clock_line   = clk_line_q;
	assign result.data_release = dat_rel_q;
	assign result.busy_res     = busy_q;
	assign result.finished     = fin_q;
	assign result.status       = st_q;

	// phase timing class
	always_comb begin
		case (phase_q)
			P_PRE, P_STA, P_STB, P_SPA, P_SPB, P_SN1A, P_SN1B, P_SN2A, P_SN2B, P_GAP:
				long_ph = 1'b1;
			default:
				long_ph = 1'b0;
		endcase
	end

	assign bright  = (shift_q == ledtw_pkg::BRIGHT_ADDR);
	assign s_ticks = (short_delay_ticks == 8'd0) ? 8'd1 : short_delay_ticks;
	assign target  = long_ph ? {s_ticks, 1'b0} : {1'b0, s_ticks};

	// next-state step for one word
	always_comb begin
		phase_d   = phase_q;
		delay_d   = delay_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		second_d  = second_q;
		refresh_d = refresh_q;
		saved_d   = saved_q;
		active_d  = active_q;
		fin_d     = 1'b0;
		st_d      = ledtw_pkg::ST_OK;
		if (phase_q == P_IDLE) begin
			case (head.cmd)
				ledtw_pkg::CMD_BRIGHT: begin
					if (head.reject) begin
						fin_d = 1'b1;
						st_d  = ledtw_pkg::ST_REJECT;
					end else begin
						shift_d  = head.addr_byte;
						second_d = head.data_byte;
						active_d = ledtw_pkg::CMD_BRIGHT;
						phase_d  = P_STA;
					end
				end
				ledtw_pkg::CMD_DIGIT: begin
					shift_d  = head.addr_byte;
					second_d = head.data_byte;
					active_d = ledtw_pkg::CMD_DIGIT;
					phase_d  = P_STA;
				end
				ledtw_pkg::CMD_REFRESH: begin
					saved_d   = head.patterns;
					refresh_d = 2'd0;
					active_d  = ledtw_pkg::CMD_REFRESH;
					phase_d   = P_PRE;
				end
				default: begin
				end
			endcase
			delay_d = 9'd0;
			bit_d   = 3'd0;
		end else if (head.tick) begin
			if (({1'b0, delay_q} + 10'd1) < {1'b0, target}) begin
				delay_d = delay_q + 9'd1;
			end else begin
				delay_d = 9'd0;
				case (phase_q)
					P_PRE: begin
						shift_d  = ledtw_pkg::BRIGHT_ADDR;
						second_d = ledtw_pkg::REFRESH_LEVEL;
						phase_d  = P_STA;
					end
					P_STA: phase_d = P_STB;
					P_STB: begin
						bit_d   = 3'd0;
						phase_d = P_B1L;
					end
					P_B1L: phase_d = P_B1H;
					P_B1H: phase_d = P_B1T;
					P_B1T: begin
						if (bit_q == 3'd7) begin
							bit_d   = 3'd0;
							phase_d = P_A1H;
						end else begin
							bit_d   = bit_q + 3'd1;
							phase_d = P_B1L;
						end
					end
					P_A1H: phase_d = (head.sda && !bright) ? P_A1N : P_A1L;
					P_A1L: begin
						bit_d   = 3'd0;
						phase_d = P_B2L;
					end
					P_A1N: phase_d = P_SN1A;
					P_B2L: phase_d = P_B2H;
					P_B2H: phase_d = P_B2T;
					P_B2T: begin
						if (bit_q == 3'd7) begin
							bit_d   = 3'd0;
							phase_d = P_A2H;
						end else begin
							bit_d   = bit_q + 3'd1;
							phase_d = P_B2L;
						end
					end
					P_A2H: phase_d = (head.sda && !bright) ? P_A2N : P_A2L;
					P_A2L: phase_d = P_SPA;
					P_A2N: phase_d = P_SN2A;
					P_SPA: phase_d = P_SPB;
					P_SPB: begin
						if (active_q == ledtw_pkg::CMD_REFRESH && bright) begin
							phase_d = P_GAP;
						end else if (active_q == ledtw_pkg::CMD_REFRESH &&
							({1'b0, refresh_q} + 3'd1) < 3'(DIGIT_COUNT)) begin
							refresh_d = refresh_q + 2'd1;
							shift_d   = ledtw_pkg::BRIGHT_ADDR;
							second_d  = ledtw_pkg::REFRESH_LEVEL;
							phase_d   = P_STA;
						end else begin
							fin_d   = 1'b1;
							phase_d = P_IDLE;
						end
					end
					P_SN1A: phase_d = P_SN1B;
					P_SN1B: begin
						fin_d   = 1'b1;
						st_d    = ledtw_pkg::ST_NACK_ADDR;
						phase_d = P_IDLE;
					end
					P_SN2A: phase_d = P_SN2B;
					P_SN2B: begin
						fin_d   = 1'b1;
						st_d    = ledtw_pkg::ST_NACK_DATA;
						phase_d = P_IDLE;
					end
					P_GAP: begin
						shift_d  = ledtw_pkg::DIGIT_ADDR + {5'd0, refresh_q, 1'b0};
						second_d = saved_q[{refresh_q, 3'b000} +: 8];
						phase_d  = P_STA;
					end
					default: phase_d = P_IDLE;
				endcase
				if (phase_d == P_IDLE) begin
					active_d = ledtw_pkg::CMD_NONE;
				end
			end
		end
	end

	// line levels of the new phase
	assign shamt = 3'd7 - bit_d;
	always_comb begin
		case (phase_d)
			P_B1L, P_B1T, P_A1L, P_A1N, P_B2L, P_B2T, P_A2L, P_A2N, P_SPA, P_SN1A,
			P_SN2A:
				clk_d = 1'b0;
			default:
				clk_d = 1'b1;
		endcase
		case (phase_d)
			P_STB, P_SPA, P_SPB, P_SN1A, P_SN1B, P_SN2A, P_SN2B:
				dat_d = 1'b0;
			P_B1L, P_B1H, P_B1T:
				dat_d = shift_d[shamt];
			P_B2L, P_B2H, P_B2T:
				dat_d = second_d[shamt];
			default:
				dat_d = 1'b1;
		endcase
	end

	// sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= P_IDLE;
			delay_q     <= 9'd0;
			bit_q       <= 3'd0;
			shift_q     <= 8'd0;
			second_q    <= 8'd0;
			refresh_q   <= 2'd0;
			saved_q     <= 32'd0;
			active_q    <= ledtw_pkg::CMD_NONE;
			out_valid_q <= 1'b0;
			clk_line_q  <= 1'b1;
			dat_rel_q   <= 1'b1;
			busy_q      <= 1'b0;
			fin_q       <= 1'b0;
			st_q        <= ledtw_pkg::ST_OK;
		end else if (pop) begin
			phase_q     <= phase_d;
			delay_q     <= delay_d;
			bit_q       <= bit_d;
			shift_q     <= shift_d;
			second_q    <= second_d;
			refresh_q   <= refresh_d;
			saved_q     <= saved_d;
			active_q    <= active_d;
			out_valid_q <= 1'b1;
			clk_line_q  <= clk_d;
			dat_rel_q   <= dat_d;
			busy_q      <= (phase_d != P_IDLE);
			fin_q       <= fin_d;
			st_q        <= st_d;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_idle_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == P_IDLE |-> active_q == ledtw_pkg::CMD_NONE)
		else $error("active command left set while idle");
	a_reject_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && st_q == ledtw_pkg::ST_REJECT |-> fin_q && !busy_q)
		else $error("rejected level started a frame");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |-> !pop)
		else $error("result overwritten while stalled");
	a_delay_bound: assert property (@(posedge clk) disable iff (!arst_n)
		delay_q < 9'd510)
		else $error("delay timer out of range");
`endif

endmodule

>>> rtl/led_driver_two_wire_writer_core.sv
// Path: an accepted word passes the front stage, the two-entry queue and the result register.
// Throughput: one word per cycle unless results stall; one sequencer step per word.
// Reset: asynchronous, active low; sequencer idle, both lines released, queue empty,
// short delay register set to one tick.
// ----------------------------------------------------------------------------
// led_driver_two_wire_writer_core: two-wire LED display writer
// Front end classifies commands, a short queue decouples it from the bus
// sequencer that drives clock and data levels frame by frame.
// ----------------------------------------------------------------------------
module led_driver_two_wire_writer_core #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,
	ledtw_in_if.sink    item,
	ledtw_out_if.source result
);

	logic [7:0]        sdt_q;
	logic              push;
	logic              pop;
	ledtw_pkg::item_t  push_data;
	ledtw_pkg::item_t  head;
	ledtw_pkg::qstat_t qstat;

	// short delay register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sdt_q <= 8'd1;
		end else if (cfg_we) begin
			sdt_q <= cfg_data;
		end
	end

	ledtw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	ledtw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	ledtw_back #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.short_delay_ticks (sdt_q),
		.head              (head),
		.qstat             (qstat),
		.pop               (pop),
		.result            (result)
	);

endmodule
